@@ sv/ppp_option_reject_filter_top_defines.svh @@
`ifndef PPP_OPTION_REJECT_FILTER_TOP_DEFINES_SVH
`define PPP_OPTION_REJECT_FILTER_TOP_DEFINES_SVH

// plain property checked on every clock outside reset
`define PPPORF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// same-cycle implication
`define PPPORF_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define PPPORF_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ sv/pporf_pkg.sv @@
`timescale 1ns / 1ps

package pporf_pkg;

    localparam int NUM_SUPPORTED = 6;
    localparam int NUM_SLOTS     = 6;
    localparam int BYTE_W        = 8;
    localparam int LEN_W         = 16;
    localparam int PROTO_W       = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 8;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 48;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = 2;
    localparam int FIFO_CNT_W    = 3;

    localparam logic [LEN_W-1:0]  HEADER_BYTES = 16'd4;
    localparam logic [LEN_W-1:0]  LEN_MAX      = 16'hFFFF;
    localparam logic [BYTE_W-1:0] MIN_OPT_LEN  = 8'd2;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  reject_byte;
        logic               reject_byte_valid;
        logic               frame_done;
        logic               any_rejected;
        logic [LEN_W-1:0]   reject_length;
        logic [PROTO_W-1:0] protocol_echo;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

@@ sv/pporf_parse.sv @@
`timescale 1ns / 1ps

`include "ppp_option_reject_filter_top_defines.svh"

module pporf_parse (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pporf_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [pporf_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                                in_acc,
    input  logic [pporf_pkg::BYTE_W-1:0]        option_byte,
    input  logic                                last_byte,
    input  logic [pporf_pkg::PROTO_W-1:0]       protocol,
    output pporf_pkg::push_t                    push
);

    logic [pporf_pkg::BYTE_W-1:0] codes_reg [pporf_pkg::NUM_SLOTS];

    pporf_pkg::phase_t            phase_reg, phase_next, phase_work;
    logic                         rej_reg, rej_next, rej_work;
    logic [pporf_pkg::BYTE_W-1:0] rem_reg, rem_next, rem_work;
    logic [pporf_pkg::LEN_W-1:0]  cnt_reg, cnt_next, cnt_work;
    logic                         seen_reg, seen_next, seen_work;

    logic                         supported;
    logic                         emit;
    logic [pporf_pkg::BYTE_W-1:0] len_clamp;
    logic [pporf_pkg::BYTE_W-1:0] rem_dec;
    pporf_pkg::result_t           rej_res, sum_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pporf_pkg::NUM_SLOTS; i++) begin
                codes_reg[i] <= '0;
            end
        end else if (cfg_wr_en && (int'(cfg_addr) < pporf_pkg::NUM_SLOTS)) begin
            codes_reg[cfg_addr] <= cfg_wr_data;
        end
    end

    // type match against enabled nonzero slots
    always_comb begin
        supported = 1'b0;
        for (int k = 0; k < pporf_pkg::NUM_SLOTS; k++) begin
            if ((k < pporf_pkg::NUM_SUPPORTED) && (codes_reg[k] != '0) &&
                (codes_reg[k] == option_byte)) begin
                supported = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        phase_work = phase_reg;
        rej_work   = rej_reg;
        rem_work   = rem_reg;
        seen_work  = seen_reg;
        emit       = 1'b0;
        len_clamp  = (option_byte < pporf_pkg::MIN_OPT_LEN) ? pporf_pkg::MIN_OPT_LEN
                                                            : option_byte;
        rem_dec    = (rem_reg != '0) ? rem_reg - 8'd1 : rem_reg;
        case (phase_reg)
            pporf_pkg::PH_LEN: begin
                emit       = rej_reg;
                rem_work   = len_clamp - pporf_pkg::MIN_OPT_LEN;
                phase_work = (rem_work == '0) ? pporf_pkg::PH_TYPE : pporf_pkg::PH_DATA;
            end
            pporf_pkg::PH_DATA: begin
                emit     = rej_reg;
                rem_work = rem_dec;
                if (rem_dec == '0) begin
                    phase_work = pporf_pkg::PH_TYPE;
                end
            end
            default: begin
                rej_work   = !supported;
                seen_work  = seen_reg | !supported;
                emit       = !supported;
                phase_work = pporf_pkg::PH_LEN;
            end
        endcase
        cnt_work = (emit && (cnt_reg != pporf_pkg::LEN_MAX)) ? cnt_reg + 16'd1 : cnt_reg;

        phase_next = phase_reg;
        rej_next   = rej_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        seen_next  = seen_reg;
        if (in_acc) begin
            if (last_byte) begin
                phase_next = pporf_pkg::PH_TYPE;
                rej_next   = 1'b0;
                rem_next   = '0;
                cnt_next   = pporf_pkg::HEADER_BYTES;
                seen_next  = 1'b0;
            end else begin
                phase_next = phase_work;
                rej_next   = rej_work;
                rem_next   = rem_work;
                cnt_next   = cnt_work;
                seen_next  = seen_work;
            end
        end
    end

    // result words
    always_comb begin
        rej_res                   = '0;
        rej_res.reject_byte       = option_byte;
        rej_res.reject_byte_valid = 1'b1;

        sum_res               = '0;
        sum_res.frame_done    = 1'b1;
        sum_res.any_rejected  = seen_work;
        sum_res.reject_length = cnt_work;
        sum_res.protocol_echo = protocol;

        push        = '0;
        push.second = sum_res;
        if (in_acc) begin
            push.num = {1'b0, emit} + {1'b0, last_byte};
        end
        push.first = emit ? rej_res : sum_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pporf_pkg::PH_TYPE;
            rej_reg   <= 1'b0;
            rem_reg   <= '0;
            cnt_reg   <= pporf_pkg::HEADER_BYTES;
            seen_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            rej_reg   <= rej_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            seen_reg  <= seen_next;
        end
    end

    `PPPORF_ASSERT_NEXT(a_region_clear, in_acc && last_byte,
        phase_reg == pporf_pkg::PH_TYPE && cnt_reg == pporf_pkg::HEADER_BYTES && !seen_reg,
        "parse state not cleared after last word")
    `PPPORF_ASSERT_IMP(a_count_vs_seen, cnt_reg != pporf_pkg::HEADER_BYTES, seen_reg,
        "rejected bytes counted without a rejected option")
    `PPPORF_ASSERT_IMP(a_data_rem, phase_reg == pporf_pkg::PH_DATA, rem_reg != '0,
        "data phase with no bytes left")

endmodule

@@ sv/pporf_fifo.sv @@
`timescale 1ns / 1ps

`include "ppp_option_reject_filter_top_defines.svh"

module pporf_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pporf_pkg::push_t      push,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pporf_pkg::result_t    out_data
);

    pporf_pkg::result_t                mem [pporf_pkg::FIFO_DEPTH];
    logic [pporf_pkg::FIFO_PTR_W-1:0]  wptr_reg, wptr_next;
    logic [pporf_pkg::FIFO_PTR_W-1:0]  rptr_reg, rptr_next;
    logic [pporf_pkg::FIFO_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                              pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem[rptr_reg];
    assign room      = (cnt_reg <= 3'd2);

    always_comb begin
        wptr_next = wptr_reg + push.num;
        rptr_next = rptr_reg + {1'b0, pop};
        cnt_next  = cnt_reg + {1'b0, push.num} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            mem[wptr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            mem[wptr_reg + 2'd1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    `PPPORF_ASSERT(a_cnt_bound, cnt_reg <= 3'd4, "result queue count out of range")
    `PPPORF_ASSERT_IMP(a_push_room, push.num != 2'd0, room,
        "words pushed without room")
    `PPPORF_ASSERT(a_ptr_gap, wptr_reg - rptr_reg == cnt_reg[pporf_pkg::FIFO_PTR_W-1:0],
        "queue pointers disagree with count")

endmodule

@@ sv/ppp_option_reject_filter_top.sv @@
`timescale 1ns / 1ps

// option reject filter for ppp configure requests
// s_ channel: one byte of the options region per word, s_tlast on the final byte,
//   protocol number carried alongside every byte (taken from the last one)
// m_ channel: one word per byte of an unsupported option (m_tuser high), then a
//   summary word with m_tlast high after the last byte: any-rejected flag,
//   reject frame length (4 plus rejected bytes, saturating) and protocol
// cfg port: six supported option codes, index 0 to 5, zero disables a slot;
//   write only while the block is idle
// results of a byte are registered in the result queue when the byte is accepted
// throughput: one byte per cycle while s_tready is high; a byte that yields
//   two words (rejected last byte) queues both at once for the single output port
// a four-word result queue decouples the sides: s_tready depends only on its
//   fill level and drops while three or more words wait, so a stalled receiver
//   holds off the input within three more bytes
// reset clears the parse state, the queue and all supported codes

module ppp_option_reject_filter_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [pporf_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [pporf_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // option_byte [7:0], protocol [23:8]
    input  logic [pporf_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // reject_byte [7:0], any_rejected [8], reject_length [24:9],
    // protocol_echo [40:25], zero [47:41]
    output logic [pporf_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tlast,
    // reject_byte_valid [0]
    output logic                                 m_tuser
);

    logic               in_acc;
    pporf_pkg::push_t   push;
    pporf_pkg::result_t res;

    assign in_acc = s_tvalid && s_tready;

    pporf_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .in_acc      (in_acc),
        .option_byte (s_tdata[7:0]),
        .last_byte   (s_tlast),
        .protocol    (s_tdata[23:8]),
        .push        (push)
    );

    pporf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {7'd0, res.protocol_echo, res.reject_length, res.any_rejected,
                      res.reject_byte};
    assign m_tlast = res.frame_done;
    assign m_tuser = res.reject_byte_valid;

endmodule
